@@ hw/rtl/pws_pkg.sv @@
package pws_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_CAND_DEF    = 64;

  localparam logic [31:0]        PRIO_MAGIC    = 32'h5052_4F49;
  localparam logic signed [31:0] FALLBACK_BASE = 32'sd10000;
  localparam logic signed [31:0] PRIO_UNKNOWN  = 32'sh8000_0000;

  localparam int POS_SAT = 63;
  localparam int CNT_SAT = 64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAND = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [15:0]        id;
    logic               found;
    logic signed [31:0] prio;
  } tok_t;

endpackage

@@ hw/rtl/pws_if.sv @@
interface pws_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [15:0]        ext_id;
  logic [31:0]        meta_tag;
  logic signed [31:0] prio_value;
  logic               last;

  modport source (output valid, cmd, ext_id, meta_tag, prio_value, last, input ready);
  modport sink   (input valid, cmd, ext_id, meta_tag, prio_value, last, output ready);
endinterface

interface pws_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         winner_index;
  logic [15:0]        winner_ext_id;
  logic signed [31:0] winner_priority;
  logic               explicit_mode;
  logic [6:0]         candidate_count;

  modport source (output valid, winner_index, winner_ext_id, winner_priority,
                  explicit_mode, candidate_count, input ready);
  modport sink   (input valid, winner_index, winner_ext_id, winner_priority,
                  explicit_mode, candidate_count, output ready);
endinterface

@@ hw/rtl/priority_winner_select_top.sv @@
// Load word: one load per cycle while the block is idle, with no candidate in flight.
// Candidate word: once it is accepted, the lookup token walks every table cell, then the
// update follows; no new word is taken until that update is done.
// On the closing candidate the result is registered by the update, after the walk;
// the update holds while an earlier result word still waits.
// Synchronous active-low reset empties the table and clears the run and output.
module priority_winner_select_top #(
  parameter int TABLE_DEPTH    = pws_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_CANDIDATES = pws_pkg::MAX_CAND_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pws_in_if.sink    in_ch,
  pws_out_if.source out_ch
);
  import pws_pkg::*;

  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int WW = CW + 7;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_UPD} state_t;

  state_t             state_r;
  logic [FW-1:0]      fill_r;
  logic [CW-1:0]      seen_r;
  logic               any_nz_r;
  logic [15:0]        cand_id_r;
  logic signed [31:0] cand_prio_r;
  logic               cand_last_r;
  logic signed [31:0] tab_prio_r;
  logic               out_valid_r;
  logic [5:0]         out_index_r;
  logic [15:0]        out_id_r;
  logic signed [31:0] out_prio_r;
  logic               out_expl_r;
  logic [6:0]         out_count_r;

  tok_t               tok [TABLE_DEPTH+1];
  logic               in_acc;
  logic               load_en;
  logic               start;
  logic               upd_go;
  logic               first;
  logic               any_nz_nxt;
  logic signed [31:0] load_prio;
  logic [CW-1:0]      seen_nxt;
  logic [WW-1:0]      cnt_w;
  logic [WW-1:0]      pos_w;
  logic signed [31:0] own_prio;
  logic [15:0]        own_id;
  logic [CW-1:0]      own_pos;
  logic signed [31:0] tab_prio;
  logic [15:0]        tab_id;
  logic [CW-1:0]      tab_pos;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_en     = in_acc && in_ch.cmd == CMD_LOAD && fill_r < FW'(TABLE_DEPTH);
  assign start       = in_acc && in_ch.cmd == CMD_CAND;
  assign load_prio   = (in_ch.meta_tag == PRIO_MAGIC) ? in_ch.prio_value
                     : FALLBACK_BASE - $signed({16'b0, in_ch.ext_id});

  assign tok[0].valid = start;
  assign tok[0].id    = in_ch.ext_id;
  assign tok[0].found = 1'b0;
  assign tok[0].prio  = PRIO_UNKNOWN;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pws_cell #(.IDX(i), .FW(FW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (load_en),
      .wr_id   (in_ch.ext_id),
      .wr_prio (load_prio),
      .fill    (fill_r),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

  assign upd_go     = (state_r == S_UPD) && (!cand_last_r || !out_valid_r || out_ch.ready);
  assign first      = (seen_r == '0);
  assign any_nz_nxt = any_nz_r | (cand_prio_r != 32'sd0);
  assign seen_nxt   = (seen_r < CW'(MAX_CANDIDATES)) ? seen_r + 1'b1 : seen_r;
  assign cnt_w      = WW'(seen_nxt);
  assign pos_w      = any_nz_nxt ? WW'(own_pos) : WW'(tab_pos);

  pws_judge #(.CW(CW)) u_own (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (upd_go),
    .clear     (cand_last_r),
    .first     (first),
    .cand_prio (cand_prio_r),
    .cand_id   (cand_id_r),
    .cand_pos  (seen_r),
    .win_prio  (own_prio),
    .win_id    (own_id),
    .win_pos   (own_pos)
  );

  pws_judge #(.CW(CW)) u_tab (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (upd_go),
    .clear     (cand_last_r),
    .first     (first),
    .cand_prio (tab_prio_r),
    .cand_id   (cand_id_r),
    .cand_pos  (seen_r),
    .win_prio  (tab_prio),
    .win_id    (tab_id),
    .win_pos   (tab_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      seen_r      <= '0;
      any_nz_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !(upd_go && cand_last_r)) begin
        out_valid_r <= 1'b0;
      end
      if (load_en) begin
        fill_r <= fill_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (tok[TABLE_DEPTH].valid) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            state_r <= S_IDLE;
            if (cand_last_r) begin
              seen_r      <= '0;
              any_nz_r    <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              seen_r   <= seen_nxt;
              any_nz_r <= any_nz_nxt;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cand_id_r   <= in_ch.ext_id;
      cand_prio_r <= in_ch.prio_value;
      cand_last_r <= in_ch.last;
    end
    if (state_r == S_WALK && tok[TABLE_DEPTH].valid) begin
      tab_prio_r <= tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].prio : PRIO_UNKNOWN;
    end
    if (upd_go && cand_last_r) begin
      out_index_r <= (pos_w > WW'(POS_SAT)) ? 6'(POS_SAT) : pos_w[5:0];
      out_id_r    <= any_nz_nxt ? own_id : tab_id;
      out_prio_r  <= any_nz_nxt ? own_prio : tab_prio;
      out_expl_r  <= any_nz_nxt;
      out_count_r <= (cnt_w > WW'(CNT_SAT)) ? 7'(CNT_SAT) : cnt_w[6:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.winner_index    = out_index_r;
  assign out_ch.winner_ext_id   = out_id_r;
  assign out_ch.winner_priority = out_prio_r;
  assign out_ch.explicit_mode   = out_expl_r;
  assign out_ch.candidate_count = out_count_r;

  a_tok_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tok[TABLE_DEPTH].valid |-> state_r == S_WALK)
    else $error("lookup token left the chain outside the walk");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(TABLE_DEPTH))
    else $error("table fill beyond depth");

  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == S_WALK)
    else $error("candidate word did not start a walk");

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD && cand_last_r))
    else $error("result raised without a closing candidate");

endmodule

@@ hw/rtl/pws_cell.sv @@
module pws_cell #(
  parameter int IDX = 0,
  parameter int FW  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [15:0]        wr_id,
  input  logic signed [31:0] wr_prio,
  input  logic [FW-1:0]      fill,
  input  pws_pkg::tok_t      tok_i,
  output pws_pkg::tok_t      tok_o
);
  import pws_pkg::*;

  logic [15:0]        ent_id_r;
  logic signed [31:0] ent_prio_r;
  logic               tok_valid_r;
  logic [15:0]        tok_id_r;
  logic               tok_found_r;
  logic signed [31:0] tok_prio_r;
  logic               hit;

  assign hit = !tok_i.found && (FW'(IDX) < fill) && (ent_id_r == tok_i.id);

  always_ff @(posedge clk) begin
    if (wr_en && fill == FW'(IDX)) begin
      ent_id_r   <= wr_id;
      ent_prio_r <= wr_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_id_r    <= tok_i.id;
    tok_found_r <= tok_i.found | hit;
    tok_prio_r  <= hit ? ent_prio_r : tok_i.prio;
  end

  assign tok_o.valid = tok_valid_r;
  assign tok_o.id    = tok_id_r;
  assign tok_o.found = tok_found_r;
  assign tok_o.prio  = tok_prio_r;

endmodule

@@ hw/rtl/pws_judge.sv @@
module pws_judge #(
  parameter int CW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  logic               clear,
  input  logic               first,
  input  logic signed [31:0] cand_prio,
  input  logic [15:0]        cand_id,
  input  logic [CW-1:0]      cand_pos,
  output logic signed [31:0] win_prio,
  output logic [15:0]        win_id,
  output logic [CW-1:0]      win_pos
);
  import pws_pkg::*;

  logic signed [31:0] best_prio_r;
  logic [15:0]        best_id_r;
  logic [CW-1:0]      best_pos_r;
  logic               beat;

  assign beat = first || (cand_prio > best_prio_r) ||
                (cand_prio == best_prio_r && cand_id < best_id_r);

  assign win_prio = beat ? cand_prio : best_prio_r;
  assign win_id   = beat ? cand_id   : best_id_r;
  assign win_pos  = beat ? cand_pos  : best_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_prio_r <= '0;
      best_id_r   <= '0;
      best_pos_r  <= '0;
    end else if (commit) begin
      if (clear) begin
        best_prio_r <= '0;
        best_id_r   <= '0;
        best_pos_r  <= '0;
      end else begin
        best_prio_r <= win_prio;
        best_id_r   <= win_id;
        best_pos_r  <= win_pos;
      end
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

typedef struct {
  logic [5:0]         pos;
  logic [15:0]        ext_id;
  logic signed [31:0] prio;
  logic               by_own;
  logic [6:0]         count;
} winner_t;

class winner_board;
  logic [15:0]        tab_ids[pws_pkg::TABLE_DEPTH_DEF];
  logic signed [31:0] tab_prios[pws_pkg::TABLE_DEPTH_DEF];
  int                 fill;
  int                 seen;
  bit                 any_set;
  logic signed [31:0] own_prio;
  logic [15:0]        own_id;
  int                 own_pos;
  logic signed [31:0] lut_prio;
  logic [15:0]        lut_id;
  int                 lut_pos;
  winner_t            pending[$];
  int                 errors;

  function new();
    fill   = 0;
    errors = 0;
    clear_run();
  endfunction

  function void clear_run();
    seen     = 0;
    any_set  = 1'b0;
    own_prio = '0;
    own_id   = '0;
    own_pos  = 0;
    lut_prio = '0;
    lut_id   = '0;
    lut_pos  = 0;
  endfunction

  function bit beats(logic signed [31:0] p, logic [15:0] id,
                     logic signed [31:0] bp, logic [15:0] bid);
    return (p > bp) || (p == bp && id < bid);
  endfunction

  function int pending_count();
    return pending.size();
  endfunction

  function void note_word(logic cmd, logic [15:0] id, logic [31:0] tag,
                          logic signed [31:0] prio, logic last);
    logic signed [31:0] tp;
    winner_t            w;
    if (cmd == pws_pkg::CMD_LOAD) begin
      if (fill < pws_pkg::TABLE_DEPTH_DEF) begin
        tab_ids[fill]   = id;
        tab_prios[fill] = (tag == pws_pkg::PRIO_MAGIC) ? prio
                          : (pws_pkg::FALLBACK_BASE - $signed({16'd0, id}));
        fill++;
      end
      return;
    end
    // scan backwards so the first matching entry is the one kept
    tp = pws_pkg::PRIO_UNKNOWN;
    for (int i = fill - 1; i >= 0; i--)
      if (tab_ids[i] == id) tp = tab_prios[i];
    if (prio != 0) any_set = 1'b1;
    if (seen == 0 || beats(prio, id, own_prio, own_id)) begin
      own_prio = prio;
      own_id   = id;
      own_pos  = seen;
    end
    if (seen == 0 || beats(tp, id, lut_prio, lut_id)) begin
      lut_prio = tp;
      lut_id   = id;
      lut_pos  = seen;
    end
    if (seen < pws_pkg::MAX_CAND_DEF) seen++;
    if (!last) return;
    w.by_own = any_set;
    w.count  = 7'((seen > pws_pkg::CNT_SAT) ? pws_pkg::CNT_SAT : seen);
    if (any_set) begin
      w.pos    = 6'((own_pos > pws_pkg::POS_SAT) ? pws_pkg::POS_SAT : own_pos);
      w.ext_id = own_id;
      w.prio   = own_prio;
    end else begin
      w.pos    = 6'((lut_pos > pws_pkg::POS_SAT) ? pws_pkg::POS_SAT : lut_pos);
      w.ext_id = lut_id;
      w.prio   = lut_prio;
    end
    pending.push_back(w);
    clear_run();
  endfunction

  function void compare(string field, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp, act);
      errors++;
    end
  endfunction

  function void check_winner(winner_t got);
    winner_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected winner word, ext_id %h", $time, got.ext_id);
      errors++;
      return;
    end
    w = pending.pop_front();
    compare("winner_index", 32'(w.pos), 32'(got.pos));
    compare("winner_ext_id", 32'(w.ext_id), 32'(got.ext_id));
    compare("winner_priority", w.prio, got.prio);
    compare("explicit_mode", 32'(w.by_own), 32'(got.by_own));
    compare("candidate_count", 32'(w.count), 32'(got.count));
  endfunction
endclass

module tb;
  localparam int ITEMS      = 1500;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL       = 2 * pws_pkg::TABLE_DEPTH_DEF + 10;

  logic clk = 1'b0;
  logic rst_n;

  pws_in_if  in_ch();
  pws_out_if out_ch();

  priority_winner_select_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  winner_board board;
  winner_t     got;
  logic [15:0] known_ids[$];
  int          idle_cycles;

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_id();
    int r = $urandom_range(0, 99);
    if (r < 55) return known_ids[$urandom_range(0, known_ids.size() - 1)];
    if (r < 65) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    if (r < 85) return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  function automatic logic signed [31:0] pick_prio(int mode);
    int r = $urandom_range(0, 99);
    if (mode == 0) return '0;
    if (mode == 2 && r < 90) return '0;
    if (r < 35) return '0;
    if (r < 65) return $signed($urandom_range(0, 4)) - 2;
    if (r < 75) return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  task automatic send_word(logic cmd, logic [15:0] id, logic [31:0] tag,
                           logic signed [31:0] prio, logic last);
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.ext_id     = id;
    in_ch.meta_tag   = tag;
    in_ch.prio_value = prio;
    in_ch.last       = last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(cmd, id, tag, prio, last);
    if (cmd == pws_pkg::CMD_LOAD) known_ids.push_back(id);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
  endtask

  task automatic drain_winners();
    hold_off(1);
    while (board.pending_count() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pos    = out_ch.winner_index;
      got.ext_id = out_ch.winner_ext_id;
      got.prio   = out_ch.winner_priority;
      got.by_own = out_ch.explicit_mode;
      got.count  = out_ch.candidate_count;
      board.check_winner(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (hold) begin
        @(negedge clk);
        out_ch.ready = 1'b1;
      end
      repeat (gap_len()) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
    end
  end

  initial begin
    int cands;
    int len;
    int mode;
    int r;
    bit steady;
    bit paused;
    board            = new();
    idle_cycles      = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = pws_pkg::CMD_LOAD;
    in_ch.ext_id     = '0;
    in_ch.meta_tag   = '0;
    in_ch.prio_value = '0;
    in_ch.last       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: all unknown, lowest id wins
    send_word(pws_pkg::CMD_CAND, 16'd5, '0, '0, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd3, '0, '0, 1'b1);
    send_word(pws_pkg::CMD_LOAD, 16'd0, pws_pkg::PRIO_MAGIC, 32'sh7fff_ffff, 1'b0);
    send_word(pws_pkg::CMD_LOAD, 16'hffff, 32'hffff_ffff, '0, 1'b0);
    send_word(pws_pkg::CMD_LOAD, 16'd100, pws_pkg::PRIO_MAGIC, 32'sh8000_0000, 1'b0);
    send_word(pws_pkg::CMD_LOAD, 16'd100, pws_pkg::PRIO_MAGIC, 32'sd5, 1'b0);
    send_word(pws_pkg::CMD_LOAD, 16'd7, pws_pkg::PRIO_MAGIC ^ 32'h1, 32'sd123, 1'b1);
    send_word(pws_pkg::CMD_CAND, 16'hffff, '0, '0, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd100, '0, '0, 1'b0);
    send_word(pws_pkg::CMD_LOAD, 16'd9, pws_pkg::PRIO_MAGIC, 32'sh7fff_ffff, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd9, '0, '0, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd0, '0, '0, 1'b1);
    send_word(pws_pkg::CMD_CAND, 16'd1, 32'hffff_ffff, 32'sh8000_0000, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd2, '0, 32'sh7fff_ffff, 1'b0);
    send_word(pws_pkg::CMD_CAND, 16'd0, '0, 32'sh7fff_ffff, 1'b1);
    // fill the table, then one load past the end
    repeat (11)
      send_word(pws_pkg::CMD_LOAD, 16'($urandom_range(0, 16'hffff)),
                ($urandom_range(0, 3) != 0) ? pws_pkg::PRIO_MAGIC : $urandom,
                $urandom, 1'($urandom_range(0, 1)));
    drain_winners();

    cands  = 0;
    paused = 1'b0;
    while (cands < ITEMS) begin
      r      = $urandom_range(0, 99);
      len    = (r < 3) ? $urandom_range(60, 80)
             : (r < 15) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      mode   = $urandom_range(0, 2);
      steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_word(pws_pkg::CMD_LOAD, 16'($urandom_range(0, 16'hffff)), $urandom,
                    $urandom, 1'($urandom_range(0, 1)));
        send_word(pws_pkg::CMD_CAND, pick_id(), $urandom, pick_prio(mode), k == len - 1);
        cands++;
        if (!steady) hold_off(gap_len());
      end
      if (!paused && cands >= ITEMS / 2) begin
        drain_winners();
        paused = 1'b1;
      end
    end

    drain_winners();
    repeat (TAIL) @(posedge clk);
    if (board.errors == 0 && board.pending_count() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/pws_pkg.sv
hw/rtl/pws_if.sv
hw/rtl/pws_cell.sv
hw/rtl/pws_judge.sv
hw/rtl/priority_winner_select_top.sv
tb/tb.sv
